### design/wrr_pkg.sv
// Shared types, codes and defaults of the weighted round-robin scheduler.
// No dependencies; wrr_front, wrr_engine and the top level import this package.
package wrr_pkg;

  localparam int QUEUES_DEF     = 4;
  localparam int FIFO_DEPTH_DEF = 16;

  // command codes
  localparam logic CMD_ENQUEUE = 1'b0;
  localparam logic CMD_SERVE   = 1'b1;

  // result status codes
  localparam logic [1:0] ST_ENQUEUED = 2'd0;
  localparam logic [1:0] ST_SERVED   = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_REJECTED = 2'd3;

  // register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_BW_Q0 = 3'd0;
  localparam logic [2:0] REG_BW_Q1 = 3'd1;
  localparam logic [2:0] REG_BW_Q2 = 3'd2;
  localparam logic [2:0] REG_BW_Q3 = 3'd3;
  localparam logic [2:0] REG_PW_Q0 = 3'd4;
  localparam logic [2:0] REG_PW_Q1 = 3'd5;
  localparam logic [2:0] REG_PW_Q2 = 3'd6;
  localparam logic [2:0] REG_PW_Q3 = 3'd7;

  // one request as the front hands it over
  typedef struct packed {
    logic       is_serve;
    logic [1:0] queue_id;
    logic [4:0] packet_count;
  } item_t;

  // configuration registers
  typedef struct packed {
    logic [3:0][7:0] bandwidth;
    logic [3:0][7:0] power;
  } cfg_t;

endpackage

### design/wrr_front.sv
// Front end: two-entry request queue that accepts and classifies requests.
// Depends on wrr_pkg.
module wrr_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           command,
  input  logic [1:0]     queue_id,
  input  logic [4:0]     packet_count,
  output logic           item_valid,
  output wrr_pkg::item_t item,
  input  logic           item_pop
);
  import wrr_pkg::*;

  item_t      entries [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready   = (count != 2'd2);
  assign item_valid = (count != 2'd0);
  assign item       = entries[rptr];
  assign push       = in_valid && in_ready;
  assign pop        = item_pop && item_valid;

  // store classified request
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr].is_serve     <= (command == CMD_SERVE);
      entries[wptr].queue_id     <= queue_id;
      entries[wptr].packet_count <= packet_count;
    end
  end

  // advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

endmodule

### design/wrr_div.sv
// Iterative restoring divider, one quotient bit per cycle, ceiling result.
// Depends on nothing beyond its ports.
module wrr_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] num,
  input  logic [15:0] den,
  output logic        done,
  output logic [15:0] quot_ceil
);

  logic [15:0] rem;
  logic [15:0] quot;
  logic [15:0] divisor;
  logic [4:0]  steps;
  logic        busy;
  logic [16:0] shifted;
  logic [16:0] diff;

  assign shifted   = {rem, quot[15]};
  assign diff      = shifted - {1'b0, divisor};
  assign quot_ceil = quot + {15'd0, (rem != 16'd0)};

  // load operands, then shift in one quotient bit per busy step
  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= 16'd0;
      quot    <= num;
      divisor <= den;
    end else if (busy) begin
      if (!diff[16]) begin
        rem  <= diff[15:0];
        quot <= {quot[14:0], 1'b1};
      end else begin
        rem  <= shifted[15:0];
        quot <= {quot[14:0], 1'b0};
      end
    end
  end

  // count steps, pulse done on the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= 5'd0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= 5'd16;
      end else if (busy) begin
        steps <= steps - 5'd1;
        if (steps == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### design/wrr_engine.sv
// Back end: packet store, per-queue FIFO state, round-robin walk and quantum
// recompute. Depends on wrr_pkg and wrr_div.
module wrr_engine #(
  parameter int QUEUES     = wrr_pkg::QUEUES_DEF,
  parameter int FIFO_DEPTH = wrr_pkg::FIFO_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  wrr_pkg::cfg_t  cfg,
  input  logic           item_valid,
  input  wrr_pkg::item_t item,
  output logic           item_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [1:0]     status,
  output logic [15:0]    request_id,
  output logic [1:0]     served_queue
);
  import wrr_pkg::*;

  localparam int QW = $clog2(QUEUES);
  localparam int HW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam int AW = $clog2(QUEUES * FIFO_DEPTH);
  localparam logic [AW-1:0] DEPTH_A = AW'(FIFO_DEPTH);
  localparam logic [HW:0]   DEPTH_S = (HW+1)'(FIFO_DEPTH);
  localparam logic [QW-1:0] LAST_Q  = QW'(QUEUES - 1);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_ENQ      = 3'd1;
  localparam logic [2:0] S_SCAN     = 3'd2;
  localparam logic [2:0] S_READ     = 3'd3;
  localparam logic [2:0] S_DIVSTART = 3'd4;
  localparam logic [2:0] S_DIVWAIT  = 3'd5;
  localparam logic [2:0] S_DONE     = 3'd6;

  logic [2:0]    state;
  logic [HW-1:0] head     [QUEUES];
  logic [CW-1:0] fill     [QUEUES];
  logic [15:0]   quantum  [QUEUES];
  logic [15:0]   weight   [QUEUES];
  logic [15:0]   served_in_turn;
  logic [QW-1:0] current_queue;
  logic          recompute_pending;
  logic [15:0]   next_request_id;
  logic [QW-1:0] work_queue;
  logic [4:0]    left;
  logic [QW-1:0] rq;
  logic [15:0]   minw;
  logic [1:0]    res_status;
  logic [15:0]   res_id;
  logic [1:0]    res_queue;

  logic [15:0]   store [QUEUES*FIFO_DEPTH];
  logic [15:0]   rdata;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;

  logic          div_start;
  logic          div_done;
  logic [15:0]   div_quot;

  logic [15:0]   minw_c;
  logic          any_fill;
  logic [HW:0]   slot_sum;
  logic [HW-1:0] slot;
  logic [15:0]   limit;
  logic [15:0]   served_inc;
  logic [QW-1:0] next_q;
  logic [QW-1:0] item_q;
  logic          item_reject;

  // packet store
  always_ff @(posedge clk) begin
    if (mem_we) store[mem_waddr] <= next_request_id - 16'd1;
    if (mem_re) rdata <= store[mem_raddr];
  end

  // register weights from configuration, zero read as one
  always_ff @(posedge clk) begin
    for (int q = 0; q < QUEUES; q++) begin
      weight[q] <= 16'((cfg.bandwidth[q] == 8'd0) ? 8'd1 : cfg.bandwidth[q]) *
                   16'((cfg.power[q] == 8'd0) ? 8'd1 : cfg.power[q]);
    end
  end

  wrr_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .num       (weight[rq]),
    .den       (minw),
    .done      (div_done),
    .quot_ceil (div_quot)
  );

  // smallest weight among non-empty queues, any queue non-empty
  always_comb begin
    minw_c   = 16'd0;
    any_fill = 1'b0;
    for (int q = 0; q < QUEUES; q++) begin
      if (fill[q] != '0) begin
        any_fill = 1'b1;
        if (minw_c == 16'd0 || weight[q] < minw_c) minw_c = weight[q];
      end
    end
  end

  // decode helpers
  always_comb begin
    item_q      = item.queue_id[QW-1:0];
    item_reject = ({1'b0, item.queue_id} >= 3'(QUEUES)) || (item.packet_count == 5'd0) ||
                  (10'(fill[item_q]) + 10'(item.packet_count) > 10'(FIFO_DEPTH));
    slot_sum    = (HW+1)'(head[work_queue]) + (HW+1)'(fill[work_queue]);
    slot        = (slot_sum >= DEPTH_S) ? HW'(slot_sum - DEPTH_S) : slot_sum[HW-1:0];
    limit       = (quantum[current_queue] == 16'd0) ? 16'd1 : quantum[current_queue];
    served_inc  = served_in_turn + 16'd1;
    next_q      = (current_queue == LAST_Q) ? '0 : current_queue + QW'(1);
    item_pop    = (state == S_IDLE) && item_valid;
    div_start   = (state == S_DIVSTART);
    mem_we      = (state == S_ENQ);
    mem_waddr   = AW'(work_queue) * DEPTH_A + AW'(slot);
    mem_raddr   = AW'(current_queue) * DEPTH_A + AW'(head[current_queue]);
    mem_re      = (state == S_SCAN) && !(current_queue == '0 && served_in_turn == 16'd0 &&
                  recompute_pending) && (fill[current_queue] != '0) &&
                  (served_in_turn < limit);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      for (int q = 0; q < QUEUES; q++) begin
        head[q]    <= '0;
        fill[q]    <= '0;
        quantum[q] <= 16'd0;
      end
      served_in_turn    <= 16'd0;
      current_queue     <= '0;
      recompute_pending <= 1'b1;
      next_request_id   <= 16'd1;
      out_valid         <= 1'b0;
    end else begin
      // drop the result once taken, unless a new one is loaded below
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            if (!item.is_serve) begin
              res_queue <= item.queue_id;
              if (item_reject) begin
                res_status <= ST_REJECTED;
                res_id     <= 16'd0;
                state      <= S_DONE;
              end else begin
                res_status      <= ST_ENQUEUED;
                res_id          <= next_request_id;
                next_request_id <= next_request_id + 16'd1;
                if (fill[item_q] == '0) recompute_pending <= 1'b1;
                work_queue <= item_q;
                left       <= item.packet_count;
                state      <= S_ENQ;
              end
            end else if (!any_fill) begin
              res_status <= ST_EMPTY;
              res_id     <= 16'd0;
              res_queue  <= 2'd0;
              state      <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_ENQ: begin
          // one packet written per cycle
          fill[work_queue] <= fill[work_queue] + CW'(1);
          left             <= left - 5'd1;
          if (left == 5'd1) state <= S_DONE;
        end
        S_SCAN: begin
          if (current_queue == '0 && served_in_turn == 16'd0 && recompute_pending) begin
            recompute_pending <= 1'b0;
            minw              <= minw_c;
            rq                <= '0;
            state             <= S_DIVSTART;
          end else if (fill[current_queue] == '0 || served_in_turn >= limit) begin
            served_in_turn <= 16'd0;
            current_queue  <= next_q;
          end else begin
            head[current_queue] <= (head[current_queue] == HW'(FIFO_DEPTH - 1)) ? '0 :
                                   head[current_queue] + HW'(1);
            fill[current_queue] <= fill[current_queue] - CW'(1);
            if (fill[current_queue] == CW'(1)) recompute_pending <= 1'b1;
            if (fill[current_queue] == CW'(1) || served_inc >= limit) begin
              served_in_turn <= 16'd0;
              current_queue  <= next_q;
            end else begin
              served_in_turn <= served_inc;
            end
            res_queue <= 2'(current_queue);
            state     <= S_READ;
          end
        end
        S_READ: begin
          res_status <= ST_SERVED;
          res_id     <= rdata;
          state      <= S_DONE;
        end
        S_DIVSTART: begin
          state <= S_DIVWAIT;
        end
        S_DIVWAIT: begin
          if (div_done) begin
            quantum[rq] <= (fill[rq] != '0 && minw != 16'd0) ? div_quot : 16'd0;
            if (rq == LAST_Q) begin
              state <= S_SCAN;
            end else begin
              rq    <= rq + QW'(1);
              state <= S_DIVSTART;
            end
          end
        end
        S_DONE: begin
          // hand result to the output register once it is free
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            status       <= res_status;
            request_id   <= res_id;
            served_queue <= res_queue;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### design/weighted_round_robin_scheduler.sv
// Weighted round-robin scheduler top level: configuration registers, front
// request queue and back-end engine. Depends on wrr_pkg, wrr_front, wrr_engine.
//
// Requests are buffered in a two-entry queue and carried out one at a time by
// the engine, which gives exactly one result per request through an output
// register. An enqueue writes the packet store once per packet, one write per
// cycle. A serve skips at most QUEUES - 1 queue turns on its way to a packet.
// When a quantum recompute is due at the start of a round, the serve first
// runs the 16-step divider once per queue. Weights are products of the
// bandwidth and power registers; write them only while no request is in
// flight.
module weighted_round_robin_scheduler #(
  parameter int QUEUES     = wrr_pkg::QUEUES_DEF,
  parameter int FIFO_DEPTH = wrr_pkg::FIFO_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [1:0]  queue_id,
  input  logic [4:0]  packet_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [15:0] request_id,
  output logic [1:0]  served_queue,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import wrr_pkg::*;

  cfg_t  cfg;
  item_t item;
  logic  item_valid;
  logic  item_pop;

  assign pready = 1'b1;

  // configuration write
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        cfg.bandwidth[i] <= 8'd1;
        cfg.power[i]     <= 8'd1;
      end
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[4:2])
        REG_BW_Q0: cfg.bandwidth[0] <= pwdata[7:0];
        REG_BW_Q1: cfg.bandwidth[1] <= pwdata[7:0];
        REG_BW_Q2: cfg.bandwidth[2] <= pwdata[7:0];
        REG_BW_Q3: cfg.bandwidth[3] <= pwdata[7:0];
        REG_PW_Q0: cfg.power[0]     <= pwdata[7:0];
        REG_PW_Q1: cfg.power[1]     <= pwdata[7:0];
        REG_PW_Q2: cfg.power[2]     <= pwdata[7:0];
        REG_PW_Q3: cfg.power[3]     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // configuration read
  always_comb begin
    unique case (paddr[4:2])
      REG_BW_Q0: prdata = {24'd0, cfg.bandwidth[0]};
      REG_BW_Q1: prdata = {24'd0, cfg.bandwidth[1]};
      REG_BW_Q2: prdata = {24'd0, cfg.bandwidth[2]};
      REG_BW_Q3: prdata = {24'd0, cfg.bandwidth[3]};
      REG_PW_Q0: prdata = {24'd0, cfg.power[0]};
      REG_PW_Q1: prdata = {24'd0, cfg.power[1]};
      REG_PW_Q2: prdata = {24'd0, cfg.power[2]};
      REG_PW_Q3: prdata = {24'd0, cfg.power[3]};
      default:   prdata = 32'd0;
    endcase
  end

  wrr_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .queue_id     (queue_id),
    .packet_count (packet_count),
    .item_valid   (item_valid),
    .item         (item),
    .item_pop     (item_pop)
  );

  wrr_engine #(
    .QUEUES     (QUEUES),
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .item_valid   (item_valid),
    .item         (item),
    .item_pop     (item_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .request_id   (request_id),
    .served_queue (served_queue)
  );

  // a served packet comes from an existing queue
  a_served_queue: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_SERVED |-> {1'b0, served_queue} < 3'(QUEUES))
    else $error("served queue out of range");

  // a rejected request carries no id
  a_reject_id: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_REJECTED |-> request_id == 16'd0)
    else $error("rejected request carries an id");

  // nothing to serve reports zero fields
  a_empty_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMPTY |-> request_id == 16'd0 && served_queue == 2'd0)
    else $error("empty result has nonzero fields");

endmodule
